[sv/wcst_pkg.sv]
// Package for the sorted word-count table: constants, symbol coding,
// controller state enum and the controller/datapath command and status structs.
// No dependencies.
package wcst_pkg;

  localparam int unsigned TableDepthDef = 512;
  localparam int unsigned MaxLettersDef = 29;
  localparam int unsigned SymW = 5;
  localparam int unsigned MinLenW = 5;
  localparam int unsigned SlotW = 9;
  localparam int unsigned DistW = 10;
  localparam int unsigned CntW = 32;

  localparam logic [7:0] ChHyphen = 8'h2d;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7a;
  localparam logic [7:0] ChUpA = 8'h41;
  localparam logic [7:0] ChUpZ = 8'h5a;
  localparam logic [SymW-1:0] SymPad = 5'd0;
  localparam logic [SymW-1:0] SymHyphen = 5'd1;
  localparam logic [SymW-1:0] SymBaseA = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FOUND_WR,
    ST_INSERT,
    ST_REPORT
  } wcst_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_byte;
    logic probe_rd;
    logic cmp_step;
    logic shift_rd;
    logic shift_wr;
    logic found_wr;
    logic insert_wr;
    logic report;
  } wcst_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic flush;
    logic search_live;
    logic hit;
    logic shift_more;
    logic full;
  } wcst_sts_t;

  function automatic logic [SymW-1:0] symbol_of(input logic [7:0] b);
    logic [SymW-1:0] s;
    s = SymPad;
    if (b == ChHyphen) s = SymHyphen;
    else if (b >= ChLowA && b <= ChLowZ) s = SymBaseA + SymW'(b - ChLowA);
    else if (b >= ChUpA && b <= ChUpZ) s = SymBaseA + SymW'(b - ChUpA);
    return s;
  endfunction

endpackage

[sv/wcst_ctrl.sv]
// Controller for the sorted word-count table: sequences byte intake,
// binary search, insertion shift and result strobe. Depends on wcst_pkg.
module wcst_ctrl
  import wcst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  wcst_sts_t sts_i,
  output wcst_cmd_t cmd_o,
  output logic      busy_o
);

  wcst_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    busy_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.take_byte = 1'b1;
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!sts_i.flush) begin
          cmd_o.report = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.search_live) begin
          cmd_o.probe_rd = 1'b1;
          state_d = ST_CMP;
        end else if (sts_i.full) begin
          state_d = ST_REPORT;
        end else begin
          state_d = ST_SHIFT_RD;
        end
      end
      ST_CMP: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.hit) state_d = ST_FOUND_WR;
        else state_d = ST_PROBE;
      end
      ST_SHIFT_RD: begin
        if (sts_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d = ST_SHIFT_WR;
        end else begin
          state_d = ST_INSERT;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = ST_SHIFT_RD;
      end
      ST_FOUND_WR: begin
        cmd_o.found_wr = 1'b1;
        state_d = ST_REPORT;
      end
      ST_INSERT: begin
        cmd_o.insert_wr = 1'b1;
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[sv/wcst_datapath.sv]
// Datapath for the sorted word-count table: word buffer, letter and count
// memories, search bounds, totals and result registers. Depends on wcst_pkg.
module wcst_datapath
  import wcst_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned MaxLetters = MaxLettersDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wcst_cmd_t          cmd_i,
  output wcst_sts_t          sts_o,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_text_i,
  input  logic [MinLenW-1:0] min_length_i,
  output logic               done_o,
  output logic               word_done_o,
  output logic               is_new_o,
  output logic               dropped_full_o,
  output logic [SlotW-1:0]   slot_o,
  output logic [CntW-1:0]    word_count_o,
  output logic [DistW-1:0]   distinct_words_o,
  output logic [CntW-1:0]    total_words_o
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned EW = $clog2(TableDepth + 1);
  localparam int unsigned LongWord = MaxLetters + 1;
  localparam int unsigned LenW = $clog2(LongWord + 1);
  localparam int unsigned RowW = MaxLetters * SymW;

  logic [RowW-1:0] letter_mem [TableDepth];
  logic [CntW-1:0] count_mem [TableDepth];

  logic [SymW-1:0] buf_q [MaxLetters];
  logic [LenW-1:0] len_q;
  logic            flush_q;
  logic [EW-1:0]   entries_q;
  logic [CntW-1:0] total_q;
  logic [EW-1:0]   lo_q, hi_q;
  logic [AW-1:0]   mid_q;
  logic [RowW-1:0] row_q;
  logic [CntW-1:0] cnt_q;
  logic [EW-1:0]   sh_q;
  logic            hit_q;
  logic [SymW-1:0] sym;
  logic [RowW-1:0] key;
  logic [EW-1:0]   mid_c;
  logic            keep;
  logic            sat_cnt;

  assign sym = symbol_of(text_byte_i);

  always_comb begin
    for (int i = 0; i < MaxLetters; i++) begin
      key[RowW-1-i*SymW -: SymW] = (LenW'(i) < len_q) ? buf_q[i] : SymPad;
    end
  end

  assign keep = (len_q != '0) && (len_q < LenW'(LongWord)) &&
                (32'(len_q) >= 32'(min_length_i));
  assign mid_c = lo_q + ((hi_q - lo_q) >> 1);
  assign sat_cnt = &cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxLetters; i++) buf_q[i] <= SymPad;
      len_q <= '0;
      flush_q <= 1'b0;
      entries_q <= '0;
      total_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      hit_q <= 1'b0;
      done_o <= 1'b0;
      word_done_o <= 1'b0;
      is_new_o <= 1'b0;
      dropped_full_o <= 1'b0;
      slot_o <= '0;
      word_count_o <= '0;
    end else begin
      done_o <= cmd_i.report;
      if (cmd_i.take_byte) begin
        hit_q <= 1'b0;
        word_done_o <= 1'b0;
        is_new_o <= 1'b0;
        dropped_full_o <= 1'b0;
        slot_o <= '0;
        word_count_o <= '0;
        if (sym != SymPad) begin
          for (int i = 0; i < MaxLetters; i++) begin
            if (LenW'(i) == len_q) buf_q[i] <= sym;
          end
          if (len_q < LenW'(LongWord)) len_q <= len_q + 1'b1;
        end
        flush_q <= (sym == SymPad) || end_of_text_i;
        lo_q <= '0;
        hi_q <= entries_q;
      end
      if (cmd_i.probe_rd) mid_q <= AW'(mid_c);
      if (cmd_i.cmp_step) begin
        if (row_q == key) hit_q <= 1'b1;
        else if (row_q < key) lo_q <= EW'(mid_q) + 1'b1;
        else hi_q <= EW'(mid_q);
      end
      if (cmd_i.found_wr) begin
        word_done_o <= 1'b1;
        slot_o <= SlotW'(mid_q);
        word_count_o <= sat_cnt ? cnt_q : cnt_q + 1'b1;
        if (!(&total_q)) total_q <= total_q + 1'b1;
      end
      if (cmd_i.insert_wr) begin
        word_done_o <= 1'b1;
        is_new_o <= 1'b1;
        slot_o <= SlotW'(lo_q);
        word_count_o <= CntW'(1);
        entries_q <= entries_q + 1'b1;
        if (!(&total_q)) total_q <= total_q + 1'b1;
      end
      if (cmd_i.report) begin
        if (flush_q) len_q <= '0;
        flush_q <= 1'b0;
        if (flush_q && keep && !hit_q && !is_new_o && entries_q >= EW'(TableDepth)) begin
          word_done_o <= 1'b1;
          dropped_full_o <= 1'b1;
          if (!(&total_q)) total_q <= total_q + 1'b1;
        end
      end
    end
  end

  // Shift pointer: walks from entries down to lo.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sh_q <= '0;
    else if (cmd_i.take_byte) sh_q <= entries_q;
    else if (cmd_i.shift_wr) sh_q <= sh_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_rd) begin
      row_q <= letter_mem[AW'(mid_c)];
      cnt_q <= count_mem[AW'(mid_c)];
    end else if (cmd_i.shift_rd) begin
      row_q <= letter_mem[AW'(sh_q - 1'b1)];
      cnt_q <= count_mem[AW'(sh_q - 1'b1)];
    end
    if (cmd_i.shift_wr) begin
      letter_mem[AW'(sh_q)] <= row_q;
      count_mem[AW'(sh_q)] <= cnt_q;
    end else if (cmd_i.insert_wr) begin
      letter_mem[AW'(lo_q)] <= key;
      count_mem[AW'(lo_q)] <= CntW'(1);
    end else if (cmd_i.found_wr) begin
      count_mem[mid_q] <= sat_cnt ? cnt_q : cnt_q + 1'b1;
    end
  end

  assign sts_o.flush = flush_q && keep;
  assign sts_o.search_live = (lo_q < hi_q) && !hit_q;
  assign sts_o.hit = (row_q == key);
  assign sts_o.shift_more = (sh_q > lo_q);
  assign sts_o.full = (entries_q >= EW'(TableDepth));

  assign distinct_words_o = DistW'(entries_q);
  assign total_words_o = total_q;

endmodule

[sv/word_count_sorted_table.sv]
// Sorted word-count table. A byte that keeps no word skips the search and goes to the strobe;
// a kept word is binary-searched and, when inserted, the entries above it are shifted
// (up to TableDepth-1 of them), one memory access per cycle. One byte in flight;
// busy high until its strobe, and the next start may be taken in that cycle.
// rst_ni clears control, totals and word buffer; the table rows are
// left unwritten (never read beyond the entry count). No clearing pass.
module word_count_sorted_table
  import wcst_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDef,
  parameter int unsigned MaxLetters = MaxLettersDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_text_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [MinLenW-1:0] cfg_data_i,
  output logic               done_o,
  output logic               word_done_o,
  output logic               is_new_o,
  output logic               dropped_full_o,
  output logic [SlotW-1:0]   slot_o,
  output logic [CntW-1:0]    word_count_o,
  output logic [DistW-1:0]   distinct_words_o,
  output logic [CntW-1:0]    total_words_o
);

  wcst_cmd_t cmd;
  wcst_sts_t sts;
  logic [MinLenW-1:0] min_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) min_len_q <= '0;
    else if (cfg_valid_i) min_len_q <= cfg_data_i;
  end

  wcst_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  wcst_datapath #(
    .TableDepth(TableDepth),
    .MaxLetters(MaxLetters)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .text_byte_i     (text_byte_i),
    .end_of_text_i   (end_of_text_i),
    .min_length_i    (min_len_q),
    .done_o          (done_o),
    .word_done_o     (word_done_o),
    .is_new_o        (is_new_o),
    .dropped_full_o  (dropped_full_o),
    .slot_o          (slot_o),
    .word_count_o    (word_count_o),
    .distinct_words_o(distinct_words_o),
    .total_words_o   (total_words_o)
  );

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.report |=> !busy && done_o) else $error("strobe without release");
  a_new_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_new_o && dropped_full_o)) else $error("new and dropped");
  a_dist_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(distinct_words_o) <= TableDepth || TableDepth > 1023)
    else $error("table overfill");
`endif

endmodule

[verif/tb_word_count_sorted_table.sv]
// Testbench for word_count_sorted_table: drives text bytes and min-length writes, predicts every result strobe
// with its own sorted-table model and compares it field by field.
// Depends on wcst_pkg and the word_count_sorted_table RTL.
`timescale 1ns / 1ps

module tb_word_count_sorted_table;
  import wcst_pkg::*;

  localparam int unsigned Depth = TableDepthDef;
  localparam int unsigned Letters = MaxLettersDef;
  localparam int unsigned LongWord = Letters + 1;
  localparam int unsigned KeyW = Letters * SymW;
  localparam int unsigned IdleLimit = 40000;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef struct {
    logic [7:0] text;
    logic       eot;
  } text_beat_t;

  typedef struct {
    logic             word_done;
    logic             is_new;
    logic             dropped_full;
    logic [SlotW-1:0] slot;
    logic [CntW-1:0]  word_count;
    logic [DistW-1:0] distinct;
    logic [CntW-1:0]  total;
  } word_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] text_byte_i = '0;
  logic end_of_text_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [MinLenW-1:0] cfg_data_i = '0;
  logic done_o, word_done_o, is_new_o, dropped_full_o;
  logic [SlotW-1:0] slot_o;
  logic [CntW-1:0] word_count_o, total_words_o;
  logic [DistW-1:0] distinct_words_o;

  word_count_sorted_table dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the table and word state.
  logic [KeyW-1:0] table_key[Depth];
  logic [CntW-1:0] table_cnt[Depth];
  int unsigned     entries = 0;
  logic [SymW-1:0] pend_sym[Letters];
  int unsigned     pend_len = 0;
  logic [CntW-1:0] words_seen = '0;
  int unsigned     min_len = 0;

  text_beat_t   text_q[$];
  word_result_t counts_q[$];
  int unsigned  errors = 0;
  int unsigned  gap = 0;
  bit           burst = 1'b0;
  int unsigned  idle_cycles = 0;
  string        vocab[$];

  function automatic logic [SymW-1:0] sym_code(input logic [7:0] b);
    if (b == ChHyphen) return SymHyphen;
    if (b >= ChLowA && b <= ChLowZ) return SymBaseA + SymW'(b - ChLowA);
    if (b >= ChUpA && b <= ChUpZ) return SymBaseA + SymW'(b - ChUpA);
    return SymPad;
  endfunction

  function automatic word_result_t count_word(input text_beat_t bt);
    word_result_t r;
    logic [SymW-1:0] s;
    logic [KeyW-1:0] key;
    int unsigned lo, hi, mid;
    bit hit;
    r = '{default: '0};
    s = sym_code(bt.text);
    if (s != SymPad) begin
      if (pend_len < Letters) pend_sym[pend_len] = s;
      if (pend_len < LongWord) pend_len++;
    end
    if (s == SymPad || bt.eot) begin
      if (pend_len >= 1 && pend_len < LongWord && pend_len >= min_len) begin
        key = '0;
        for (int i = 0; i < Letters; i++)
          if (i < pend_len) key[(Letters-1-i)*SymW +: SymW] = pend_sym[i];
        r.word_done = 1'b1;
        if (words_seen != CntMax) words_seen++;
        lo = 0;
        hi = entries;
        hit = 1'b0;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (table_key[mid] == key) begin
            lo = mid;
            hit = 1'b1;
            break;
          end
          if (table_key[mid] < key) lo = mid + 1;
          else hi = mid;
        end
        if (hit) begin
          if (table_cnt[lo] != CntMax) table_cnt[lo]++;
          r.slot = SlotW'(lo);
          r.word_count = table_cnt[lo];
        end else if (entries >= Depth) begin
          r.dropped_full = 1'b1;
        end else begin
          for (int i = entries; i > lo; i--) begin
            table_key[i] = table_key[i-1];
            table_cnt[i] = table_cnt[i-1];
          end
          table_key[lo] = key;
          table_cnt[lo] = 1;
          entries++;
          r.is_new = 1'b1;
          r.slot = SlotW'(lo);
          r.word_count = 1;
        end
      end
      pend_len = 0;
    end
    r.distinct = DistW'(entries);
    r.total = words_seen;
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: hold start until the beat is taken, then draw the gap to the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap <= 0;
    end else if (start && !busy) begin
      counts_q.push_back(count_word('{text_byte_i, end_of_text_i}));
      if (burst && text_q.size() > 0) begin
        text_byte_i <= text_q[0].text;
        end_of_text_i <= text_q[0].eot;
        void'(text_q.pop_front());
      end else begin
        start <= 1'b0;
        gap <= burst ? 0 : $urandom_range(0, 18);
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else if (text_q.size() > 0) begin
        text_byte_i <= text_q[0].text;
        end_of_text_i <= text_q[0].eot;
        void'(text_q.pop_front());
        start <= 1'b1;
        if (!burst) gap <= $urandom_range(0, 18);
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    word_result_t w;
    if (rst_ni && done_o) begin
      if (counts_q.size() == 0) begin
        report("unexpected strobe", 1, 0);
      end else begin
        w = counts_q.pop_front();
        if (word_done_o !== w.word_done) report("word_done", word_done_o, w.word_done);
        if (is_new_o !== w.is_new) report("is_new", is_new_o, w.is_new);
        if (dropped_full_o !== w.dropped_full)
          report("dropped_full", dropped_full_o, w.dropped_full);
        if (slot_o !== w.slot) report("slot", slot_o, w.slot);
        if (word_count_o !== w.word_count) report("word_count", word_count_o, w.word_count);
        if (distinct_words_o !== w.distinct)
          report("distinct_words", distinct_words_o, w.distinct);
        if (total_words_o !== w.total) report("total_words", total_words_o, w.total);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic eot);
    text_q.push_back('{b, eot});
  endtask

  function automatic logic [7:0] rand_delim();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = 8'h20;
      1: b = 8'h2c;
      2: b = 8'h0a;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (sym_code(b) != SymPad);
      end
    endcase
    return b;
  endfunction

  task automatic push_word(input string w, input bit eot_end);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (c >= ChLowA && c <= ChLowZ && $urandom_range(0, 3) == 0) c = c - 8'h20;
      push_beat(c, eot_end && i == w.len() - 1);
    end
    if (!eot_end) push_beat(rand_delim(), $urandom_range(0, 9) == 0);
  endtask

  function automatic string rand_word(input int unsigned len);
    string w;
    w = "";
    for (int i = 0; i < len; i++)
      w = {w, string'($urandom_range(0, 12) == 0 ? 8'h2d : 8'(ChLowA + $urandom_range(0, 25)))};
    return w;
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (text_q.size() > 0 || start || busy || counts_q.size() > 0);
  endtask

  task automatic write_min_len(input int unsigned v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= MinLenW'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    min_len = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_text(input int unsigned n);
    int unsigned stop;
    stop = text_q.size() + n;
    while (text_q.size() < stop) begin
      case ($urandom_range(0, 9))
        0: push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 1));
        1: push_word(rand_word($urandom_range(28, 33)), $urandom_range(0, 1));
        2, 3: push_word(rand_word($urandom_range(1, 8)), $urandom_range(0, 3) == 0);
        default: push_word(vocab[$urandom_range(0, vocab.size() - 1)], $urandom_range(0, 5) == 0);
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 24; i++) vocab.push_back(rand_word($urandom_range(1, 6)));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_min_len(0);
    push_word("a", 0);
    push_word("zz", 0);
    push_word("a", 1);
    push_beat(8'h2d, 0);
    push_beat(8'h00, 0);
    push_beat(8'h20, 1);
    push_beat(8'hff, 0);
    push_beat(8'h40, 0);
    push_beat(8'h5b, 0);
    push_beat(8'h60, 0);
    push_beat(8'h7b, 0);
    push_word("abcdefghijklmnopqrstuvwxyz-ab", 0);
    push_word("abcdefghijklmnopqrstuvwxyz-abc", 1);
    push_word("abcdefghijklmnopqrstuvwxyz-abcdefg", 0);
    push_word("AZ-z", 0);
    push_word("-", 1);
    push_word("a", 0);
    wait_idle();

    write_min_len(1);
    random_text(120);
    write_min_len(30);
    push_word("abcdefghijklmnopqrstuvwxyz-ab", 0);
    push_word("word", 1);
    write_min_len(3);
    burst = 1'b1;
    random_text(80);
    write_min_len(0);
    burst = 1'b0;
    random_text(100);

    write_min_len(2);
    random_text(50);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
